// File: rtl/lz77_token_decoder_top_macros.svh
// Assertion macros shared by the LZ77 token decoder RTL.
`ifndef LZ77_TOKEN_DECODER_TOP_MACROS_SVH
`define LZ77_TOKEN_DECODER_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define LZ77TD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define LZ77TD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/lz77td_pkg.sv
// Types and sequencer codes for the LZ77 token decoder.
package lz77td_pkg;

    localparam int OFFSET_W  = 12;
    localparam int LENGTH_W  = 6;
    localparam int BYTE_W    = 8;

    typedef logic [1:0] dec_state_t;

    // Sequencer codes.
    localparam dec_state_t ST_IDLE = 2'd0;
    localparam dec_state_t ST_RD   = 2'd1;
    localparam dec_state_t ST_WR   = 2'd2;
    localparam dec_state_t ST_LIT  = 2'd3;

    typedef logic [OFFSET_W-1:0] offset_t;
    typedef logic [LENGTH_W-1:0] length_t;
    typedef logic [BYTE_W-1:0]   byte_t;

endpackage

// File: rtl/lz77_token_decoder_top.sv
// LZ77 token decoder top level: history window, copy sequencer and output register.
//
//  Channel  | Direction | Handshake             | Payload
//  ---------+-----------+-----------------------+--------------------------------------
//  token    | in        | tok_valid / tok_stall | match_offset, match_length, literal_byte
//  byte     | out       | byte_valid/byte_stall | out_byte, last_of_run, bad_offset
//
// Steps: a token is taken in while the sequencer is idle; each copied byte needs a read of the
// history memory, whose read data is registered, then a write of the byte back that also
// loads the output register; the literal comes last, and only then is a new token taken.
// The single-port-write, single-port-read history memory sets that order.
// Reset: rst_n clears the sequencer, the write pointer and the produced-byte count at once;
// the history memory is not cleared, as a read never reaches beyond the bytes produced.
// Stalls: byte_stall holds the output register and the sequencer waits on it; tok_stall is
// high whenever a token is still being worked on.

`include "lz77_token_decoder_top_macros.svh"

module lz77_token_decoder_top
    import lz77td_pkg::*;
#(
    parameter int WINDOW_SIZE   = 4096,
    parameter int MAX_MATCH_LEN = 63
)
(
    input  logic    clk,
    input  logic    rst_n,

    input  logic    tok_valid,
    output logic    tok_stall,
    input  offset_t match_offset,
    input  length_t match_length,
    input  byte_t   literal_byte,

    output logic    byte_valid,
    input  logic    byte_stall,
    output byte_t   out_byte,
    output logic    last_of_run,
    output logic    bad_offset
);

    // Address width of the window, width of the produced-byte count (which reaches the window
    // size itself) and a compare width that holds both the offset and that count plus a carry.
    localparam int AW = $clog2(WINDOW_SIZE);
    localparam int PW = $clog2(WINDOW_SIZE + 1);
    localparam int CW = ((PW > OFFSET_W) ? PW : OFFSET_W) + 1;

    // The history window is a plain memory: one write and one registered read per cycle.
    byte_t             hist_mem [WINDOW_SIZE];
    byte_t             rdata_reg;
    logic [AW-1:0]     raddr;
    logic              mem_we;
    byte_t             mem_wdata;

    dec_state_t        state_reg,    state_next;
    offset_t           off_reg,      off_next;
    length_t           cnt_reg,      cnt_next;
    byte_t             lit_reg,      lit_next;
    logic              bad_reg,      bad_next;
    logic [AW-1:0]     wp_reg,       wp_next;
    logic [PW-1:0]     produced_reg, produced_next;

    logic              ov_reg,       ov_next;
    byte_t             ob_reg,       ob_next;
    logic              ol_reg,       ol_next;
    logic              obad_reg,     obad_next;

    logic              tok_accept;
    logic              out_free;
    logic              emit;
    logic              tok_bad;
    length_t           len_clamped;
    logic [CW-1:0]     wp_ext;
    logic [CW-1:0]     off_ext;
    logic [CW-1:0]     rd_ext;
    logic [AW-1:0]     wp_inc;
    logic [PW-1:0]     produced_inc;

    assign tok_stall  = (state_reg != ST_IDLE);
    assign tok_accept = tok_valid && !tok_stall;

    // The output register can take a new byte when it is empty or its byte leaves this cycle.
    assign out_free   = !ov_reg || !byte_stall;

    assign byte_valid  = ov_reg;
    assign out_byte    = ob_reg;
    assign last_of_run = ol_reg;
    assign bad_offset  = obad_reg;

    // A copy may only reach back over bytes that exist; a zero offset never copies.
    assign tok_bad     = (match_offset != '0) &&
                         (CW'(match_offset) > CW'(produced_reg));
    assign len_clamped = (match_length > LENGTH_W'(MAX_MATCH_LEN)) ?
                         LENGTH_W'(MAX_MATCH_LEN) : match_length;

    // Read address: offset bytes behind the write pointer, wrapping round the window.
    assign wp_ext  = CW'(wp_reg);
    assign off_ext = CW'(off_reg);
    assign rd_ext  = (wp_ext >= off_ext) ? (wp_ext - off_ext)
                                         : (wp_ext + CW'(WINDOW_SIZE) - off_ext);
    assign raddr   = rd_ext[AW-1:0];

    assign wp_inc       = (wp_reg == AW'(WINDOW_SIZE - 1)) ? '0 : (wp_reg + 1'b1);
    assign produced_inc = (produced_reg == PW'(WINDOW_SIZE)) ? produced_reg
                                                             : (produced_reg + 1'b1);

    // Every byte that reaches the output register is also written into the history.
    assign emit      = ((state_reg == ST_WR) || (state_reg == ST_LIT)) && out_free;
    assign mem_we    = emit;
    assign mem_wdata = (state_reg == ST_LIT) ? lit_reg : rdata_reg;

    always_comb
    begin
        state_next    = state_reg;
        off_next      = off_reg;
        cnt_next      = cnt_reg;
        lit_next      = lit_reg;
        bad_next      = bad_reg;
        wp_next       = wp_reg;
        produced_next = produced_reg;
        ov_next       = ov_reg && byte_stall;
        ob_next       = ob_reg;
        ol_next       = ol_reg;
        obad_next     = obad_reg;

        if (emit)
        begin
            wp_next       = wp_inc;
            produced_next = produced_inc;
            ov_next       = 1'b1;
            ob_next       = mem_wdata;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (tok_accept)
                begin
                    off_next = match_offset;
                    cnt_next = len_clamped;
                    lit_next = literal_byte;
                    bad_next = tok_bad;
                    if ((match_offset == '0) || tok_bad || (len_clamped == '0))
                    begin
                        state_next = ST_LIT;
                    end
                    else
                    begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD:
            begin
                state_next = ST_WR;
            end
            ST_WR:
            begin
                if (out_free)
                begin
                    ol_next   = 1'b0;
                    obad_next = 1'b0;
                    cnt_next  = cnt_reg - 1'b1;
                    state_next = (cnt_reg == LENGTH_W'(1)) ? ST_LIT : ST_RD;
                end
            end
            ST_LIT:
            begin
                if (out_free)
                begin
                    ol_next    = 1'b1;
                    obad_next  = bad_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            wp_reg       <= '0;
            produced_reg <= '0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            wp_reg       <= wp_next;
            produced_reg <= produced_next;
            ov_reg       <= ov_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        off_reg  <= off_next;
        cnt_reg  <= cnt_next;
        lit_reg  <= lit_next;
        bad_reg  <= bad_next;
        ob_reg   <= ob_next;
        ol_reg   <= ol_next;
        obad_reg <= obad_next;
    end

    // History memory. The read in the RD state sees a byte written at the end of the previous
    // WR state, so copies that overlap the bytes being written repeat them correctly.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hist_mem[wp_reg] <= mem_wdata;
        end
        rdata_reg <= hist_mem[raddr];
    end

    // The produced-byte count saturates at the window size.
    `LZ77TD_ASSERT_NOW(a_produced_cap, 1'b1, produced_reg <= PW'(WINDOW_SIZE), "produced count overflow")

    // A copied byte is only written while some of the copy is still outstanding.
    `LZ77TD_ASSERT_NOW(a_copy_count, state_reg == ST_WR, cnt_reg != '0, "copy step with zero count")

    // The literal step always ends the token with a marked byte on the output.
    `LZ77TD_ASSERT_NEXT(a_literal_last, (state_reg == ST_LIT) && out_free, byte_valid && last_of_run && (state_reg == ST_IDLE), "literal not marked last")

    // A skipped copy is only ever flagged on the closing byte of a token.
    `LZ77TD_ASSERT_NOW(a_bad_on_last, byte_valid && bad_offset, last_of_run, "bad offset flag on copied byte")

endmodule

// File: verif/lz77_token_decoder_checker.sv
// Scoreboard for the LZ77 token decoder: models the history window and checks each output byte.
`timescale 1ns / 1ps

module lz77_token_decoder_checker
    import lz77td_pkg::*;
#(
    parameter int WINDOW_SIZE   = 4096,
    parameter int MAX_MATCH_LEN = 63
)
(
    input  logic    clk,
    input  logic    rst_n,

    input  logic    tok_valid,
    input  logic    tok_stall,
    input  offset_t match_offset,
    input  length_t match_length,
    input  byte_t   literal_byte,

    input  logic    byte_valid,
    input  logic    byte_stall,
    input  byte_t   out_byte,
    input  logic    last_of_run,
    input  logic    bad_offset,

    output int      fail_count,
    output int      pending,
    output int      tokens_seen,
    output int      bytes_seen,
    output int      bad_seen,
    output int      copied_seen
);

    typedef struct packed {
        byte_t value;
        logic  last;
        logic  bad;
    } out_beat_t;

    out_beat_t   expected_bytes[$];
    byte_t       window_mem [WINDOW_SIZE];
    int unsigned wr_ptr   = 0;
    int unsigned produced = 0;

    initial
    begin
        fail_count  = 0;
        pending     = 0;
        tokens_seen = 0;
        bytes_seen  = 0;
        bad_seen    = 0;
        copied_seen = 0;
    end

    task automatic store_byte(input byte_t value);
        window_mem[wr_ptr] = value;
        wr_ptr = (wr_ptr + 1) % WINDOW_SIZE;
        if (produced < WINDOW_SIZE)
            produced++;
    endtask

    // Appends one expected byte at the tail of the queue.
    task automatic queue_beat(input byte_t value, input logic last, input logic bad);
        out_beat_t beat;
        beat = '{value, last, bad};
        expected_bytes.insert(expected_bytes.size(), beat);
    endtask

    // Expands one token into the bytes it must produce, updating the history as it goes so
    // that overlapping copies read back bytes written earlier in the same token.
    task automatic decode_token(input offset_t off, input length_t len, input byte_t lit);
        int unsigned copy_len;
        int unsigned rd_ptr;
        logic        skipped;
        byte_t       value;
        copy_len = (len > MAX_MATCH_LEN) ? MAX_MATCH_LEN : len;
        skipped  = 1'b0;
        if (off != 0)
        begin
            if (off > produced)
            begin
                skipped = 1'b1;
                bad_seen++;
            end
            else
            begin
                for (int i = 0; i < copy_len; i++)
                begin
                    rd_ptr = (wr_ptr + WINDOW_SIZE - off) % WINDOW_SIZE;
                    value  = window_mem[rd_ptr];
                    store_byte(value);
                    queue_beat(value, 1'b0, 1'b0);
                    copied_seen++;
                end
            end
        end
        store_byte(lit);
        queue_beat(lit, 1'b1, skipped);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        out_beat_t exp_beat;
        if (!rst_n)
        begin
            expected_bytes.delete();
            wr_ptr   = 0;
            produced = 0;
            pending  = 0;
        end
        else
        begin
            // Output first: a byte leaving in this cycle cannot belong to a token taken now.
            if (byte_valid === 1'b1 && byte_stall === 1'b0)
            begin
                bytes_seen++;
                if (expected_bytes.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected byte %02h last %b bad %b",
                                 $realtime, out_byte, last_of_run, bad_offset);
                end
                else
                begin
                    exp_beat = expected_bytes.pop_front();
                    if (out_byte !== exp_beat.value || last_of_run !== exp_beat.last ||
                        bad_offset !== exp_beat.bad)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: byte %0d expected %02h/%b/%b got %02h/%b/%b",
                                     $realtime, bytes_seen, exp_beat.value, exp_beat.last,
                                     exp_beat.bad, out_byte, last_of_run, bad_offset);
                    end
                end
            end
            if (tok_valid === 1'b1 && tok_stall === 1'b0)
            begin
                tokens_seen++;
                decode_token(match_offset, match_length, literal_byte);
            end
            pending = expected_bytes.size();
        end
    end

endmodule

// File: verif/lz77_token_decoder_top_test.sv
// Testbench top for the LZ77 token decoder: token stimulus, output stalls and the verdict.
`timescale 1ns / 1ps

module lz77_token_decoder_top_test;
    import lz77td_pkg::*;

    localparam int WINDOW_SIZE   = 4096;
    localparam int MAX_MATCH_LEN = 63;
    // A token's copy length is capped at MAX_MATCH_LEN, and stalls and sender gaps are short,
    // so reaching IDLE_LIMIT without any transaction can only mean a hang.
    localparam int IDLE_LIMIT    = 4000;
    localparam int RANDOM_TOKENS = 400;
    // Quiet period after the last expected byte, long enough for a stray long copy to show.
    localparam int DRAIN_CYCLES  = 2 * MAX_MATCH_LEN + 40;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    tok_valid    = 1'b0;
    logic    tok_stall;
    offset_t match_offset = '0;
    length_t match_length = '0;
    byte_t   literal_byte = '0;
    logic    byte_valid;
    logic    byte_stall   = 1'b0;
    byte_t   out_byte;
    logic    last_of_run;
    logic    bad_offset;

    int fail_count;
    int pending;
    int tokens_seen;
    int bytes_seen;
    int bad_seen;
    int copied_seen;

    // Sender pacing and the stimulus side's own view of how much history exists, which is
    // all it needs to aim offsets inside or just outside the valid window.
    int          burst_left   = 0;
    int unsigned history_fill = 0;
    int          idle_cycles  = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    lz77_token_decoder_top #(
        .WINDOW_SIZE   (WINDOW_SIZE),
        .MAX_MATCH_LEN (MAX_MATCH_LEN)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .tok_valid    (tok_valid),
        .tok_stall    (tok_stall),
        .match_offset (match_offset),
        .match_length (match_length),
        .literal_byte (literal_byte),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .out_byte     (out_byte),
        .last_of_run  (last_of_run),
        .bad_offset   (bad_offset)
    );

    lz77_token_decoder_checker #(
        .WINDOW_SIZE   (WINDOW_SIZE),
        .MAX_MATCH_LEN (MAX_MATCH_LEN)
    ) token_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .tok_valid    (tok_valid),
        .tok_stall    (tok_stall),
        .match_offset (match_offset),
        .match_length (match_length),
        .literal_byte (literal_byte),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .out_byte     (out_byte),
        .last_of_run  (last_of_run),
        .bad_offset   (bad_offset),
        .fail_count   (fail_count),
        .pending      (pending),
        .tokens_seen  (tokens_seen),
        .bytes_seen   (bytes_seen),
        .bad_seen     (bad_seen),
        .copied_seen  (copied_seen)
    );

    // The receiver stalls in modes that change at random: never, now and then, or about half
    // the time. Each stall decision is held for a short run of cycles, so stalls land on both
    // the read and the write cycle of a copy as well as on the literal.
    int stall_mode = 0;
    int mode_left  = 0;
    int stall_left = 0;

    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(50, 300);
        end
        mode_left--;
        if (stall_left == 0)
        begin
            stall_left = $urandom_range(1, 6);
            case (stall_mode)
                0:       byte_stall <= 1'b0;
                1:       byte_stall <= ($urandom_range(0, 4) == 0);
                default: byte_stall <= ($urandom_range(0, 1) == 1);
            endcase
        end
        stall_left--;
    end

    // Watchdog: counts cycles in which neither channel completes a transaction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((tok_valid === 1'b1 && tok_stall === 1'b0) ||
                (byte_valid === 1'b1 && byte_stall === 1'b0))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Presents one token at a falling edge and holds it until a rising edge takes it. Tokens
    // go out in bursts; between bursts valid drops for a random gap. A burst that continues
    // keeps valid high across the boundary, so valid is never lowered and raised in one step.
    task automatic send_token(input offset_t off, input length_t len, input byte_t lit);
        if (burst_left == 0)
        begin
            @(negedge clk);
            tok_valid <= 1'b0;
            repeat ($urandom_range(0, 9)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge clk);
        tok_valid    <= 1'b1;
        match_offset <= off;
        match_length <= len;
        literal_byte <= lit;
        do
            @(posedge clk);
        while (!(tok_valid === 1'b1 && tok_stall === 1'b0));
        // A copy only happens when the offset lies inside what has been produced so far.
        if (off != 0 && off <= history_fill)
            history_fill += len + 1;
        else
            history_fill += 1;
        if (history_fill > WINDOW_SIZE)
            history_fill = WINDOW_SIZE;
    endtask

    initial
    begin
        int          pick;
        int unsigned max_off;
        offset_t     off;
        length_t     len;

        // Reset is released on a falling edge.
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed tokens. An empty history makes any nonzero offset bad, including the
        // largest one with every field at its maximum.
        send_token(12'd1, 6'd5, 8'h00);
        send_token(12'hFFF, 6'h3F, 8'hFF);
        // Offset zero: literal only, whatever the length says.
        send_token(12'd0, 6'h3F, 8'hFF);
        send_token(12'd0, 6'd0, 8'h00);
        // A valid offset with zero length gives just the literal.
        send_token(12'd1, 6'd0, 8'h5A);
        // Overlapping copies: offset one repeats a single byte over the longest run, offset
        // three repeats a three-byte pattern.
        send_token(12'd1, 6'h3F, 8'hA5);
        send_token(12'd3, 6'd10, 8'h3C);
        // Offsets right at the oldest byte produced, and one past it.
        send_token(offset_t'(history_fill), 6'd20, 8'h81);
        send_token(offset_t'(history_fill + 1), 6'd7, 8'h7E);
        send_token(12'd2, 6'd1, 8'h01);
        send_token(12'd64, 6'd32, 8'h10);
        // Top offset bit set while the history is still short.
        send_token(12'd2048, 6'd12, 8'hC3);

        // Random tokens: mostly valid copies with random content, a tenth with offset zero and
        // a tenth aimed beyond the history while such an offset still exists.
        for (int n = 0; n < RANDOM_TOKENS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                len = length_t'($urandom_range(0, 15));
            else if (pick < 95)
                len = length_t'($urandom_range(16, 62));
            else
                len = 6'h3F;

            pick    = $urandom_range(0, 99);
            max_off = (history_fill > 4095) ? 4095 : history_fill;
            if (pick < 10 || history_fill == 0)
                off = 12'd0;
            else if (pick < 20 && history_fill < 4095)
                off = offset_t'($urandom_range(history_fill + 1, 4095));
            else if ($urandom_range(0, 1) == 0)
                off = offset_t'($urandom_range(1, (max_off < 16) ? max_off : 16));
            else
                off = offset_t'($urandom_range(1, max_off));

            send_token(off, len, byte_t'($urandom_range(0, 255)));
        end

        // Make sure the window has wrapped, then reach back to its far end.
        while (history_fill < WINDOW_SIZE)
            send_token(12'd1, 6'h3F, byte_t'($urandom_range(0, 255)));
        send_token(12'hFFF, 6'h3F, 8'h00);
        send_token(12'hFFF, 6'd0, 8'hFF);
        send_token(12'd2048, 6'd40, 8'h96);

        @(negedge clk);
        tok_valid <= 1'b0;

        // Wait for every expected byte, then keep watching for anything extra.
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Decoded %0d tokens into %0d bytes, %0d copied from history.",
                 tokens_seen, bytes_seen, copied_seen);
        $display("%0d tokens had an offset beyond the history; the window wrapped at least once.",
                 bad_seen);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: lz77_token_decoder_top.f
+incdir+rtl
rtl/lz77td_pkg.sv
rtl/lz77_token_decoder_top.sv
verif/lz77_token_decoder_checker.sv
verif/lz77_token_decoder_top_test.sv
